// ===== src/stbs_pkg.sv =====
package stbs_pkg;

  // Fixed field widths
  localparam int DefaultDepth = 256;
  localparam int ValueW       = 32;
  localparam int IndexW       = 8;
  localparam int LenW         = 9;
  localparam int PosW         = 8;

  typedef enum logic {
    MODE_WRITE  = 1'b0,
    MODE_SEARCH = 1'b1
  } stbs_mode_e;

  // Control and payload that travel with each beat through the probe stages
  typedef struct packed {
    logic                     valid;
    stbs_mode_e               mode;
    logic                     wr_ok;
    logic                     found;
    logic signed [ValueW-1:0] value;
  } stbs_ctrl_t;

endpackage

// ===== src/stbs_probe_stage.sv =====
module stbs_probe_stage #(
  parameter int TABLE_DEPTH = stbs_pkg::DefaultDepth,
  localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CntW  = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  stbs_pkg::stbs_ctrl_t in_ctrl_i,
  input  logic [AddrW-1:0]    in_widx_i,
  input  logic [CntW-1:0]     in_lo_i,
  input  logic [CntW-1:0]     in_hi_i,
  input  logic [CntW-1:0]     in_mid_i,
  input  logic [AddrW-1:0]    in_pos_i,
  output stbs_pkg::stbs_ctrl_t out_ctrl_o,
  output logic [AddrW-1:0]    out_widx_o,
  output logic [CntW-1:0]     out_lo_o,
  output logic [CntW-1:0]     out_hi_o,
  output logic [CntW-1:0]     out_mid_o,
  output logic [AddrW-1:0]    out_pos_o
);
  import stbs_pkg::*;

  // Private copy of the table, updated as write beats pass this stage
  logic [ValueW-1:0] mem [TABLE_DEPTH];

  stbs_ctrl_t               ctrl_q;
  logic [AddrW-1:0]         widx_q;
  logic [CntW-1:0]          lo_q;
  logic [CntW-1:0]          hi_q;
  logic [CntW-1:0]          mid_q;
  logic [AddrW-1:0]         pos_q;
  logic signed [ValueW-1:0] rdata_q;

  stbs_ctrl_t       ctrl_d;
  logic [CntW-1:0]  lo_d;
  logic [CntW-1:0]  hi_d;
  logic [CntW-1:0]  mid_d;
  logic [AddrW-1:0] pos_d;
  logic [CntW:0]    sum;
  logic             active;
  logic             hit;
  logic             less;

  // Hold control across stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (adv_i) begin
      ctrl_q <= in_ctrl_i;
    end
  end

  // Advance payload and probe the table at the incoming midpoint
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      widx_q  <= in_widx_i;
      lo_q    <= in_lo_i;
      hi_q    <= in_hi_i;
      mid_q   <= in_mid_i;
      pos_q   <= in_pos_i;
      rdata_q <= mem[in_mid_i[AddrW-1:0]];
    end
  end

  // Apply a write beat to this copy as it enters the stage
  always_ff @(posedge clk_i) begin
    if (adv_i && in_ctrl_i.valid && in_ctrl_i.mode == MODE_WRITE && in_ctrl_i.wr_ok) begin
      mem[in_widx_i] <= in_ctrl_i.value;
    end
  end

  // Compare the probed entry and narrow the bounds (hi is exclusive)
  always_comb begin
    active = ctrl_q.valid && ctrl_q.mode == MODE_SEARCH && !ctrl_q.found && (lo_q < hi_q);
    hit    = rdata_q == ctrl_q.value;
    less   = rdata_q < ctrl_q.value;
    ctrl_d = ctrl_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    pos_d  = pos_q;
    if (active) begin
      if (hit) begin
        ctrl_d.found = 1'b1;
        pos_d        = mid_q[AddrW-1:0];
      end else if (less) begin
        lo_d = CntW'(mid_q + 1'b1);
      end else begin
        hi_d = mid_q;
      end
    end
    // Floor midpoint of the inclusive range for the next probe
    sum   = {1'b0, lo_d} + {1'b0, hi_d} - (CntW + 1)'(1);
    mid_d = sum[CntW:1];
  end

  assign out_ctrl_o = ctrl_d;
  assign out_widx_o = widx_q;
  assign out_lo_o   = lo_d;
  assign out_hi_o   = hi_d;
  assign out_mid_o  = mid_d;
  assign out_pos_o  = pos_d;

`ifndef SYNTHESIS
  // The probed midpoint lies inside the live range
  a_mid_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active |-> (mid_q >= lo_q) && (mid_q < hi_q))
    else $error("probe midpoint outside search bounds");

  // Bounds only shrink from stage to stage
  a_bounds_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active |-> (lo_d >= lo_q) && (hi_d <= hi_q))
    else $error("search bounds widened");

  // A write beat never reports a match
  a_write_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_q.valid && ctrl_q.mode == MODE_WRITE) |-> !ctrl_d.found)
    else $error("write beat marked found");
`endif

endmodule

// ===== src/sorted_table_binary_search_unit.sv =====
// Pipeline: an accepted search beat passes through one probe stage per table probe, then
//   through the result register before its result shows.
// Throughput: one beat per cycle when not stalled; each stage owns a copy of the table.
// Write beats travel the same stages, update each copy in order, and give no result.
// Reset clears the valid bits and table_length; table contents are undefined until written.
module sorted_table_binary_search_unit #(
  parameter int TABLE_DEPTH = stbs_pkg::DefaultDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration: table_length
  input  logic                       cfg_we_i,
  input  logic [stbs_pkg::LenW-1:0]  cfg_wdata_i,
  // Input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [39:0]                s_axis_tdata,  // [7:0] entry_index, [39:8] item_value
  input  logic                       s_axis_tuser,  // [0] mode
  // Result stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,  // [7:0] position
  output logic                       m_axis_tuser   // [0] found
);
  import stbs_pkg::*;

  localparam int AddrW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW      = $clog2(TABLE_DEPTH + 1);
  localparam int NumProbes = CntW;

  logic [LenW-1:0]   len_q;
  logic              adv;
  logic [IndexW-1:0] in_idx;
  logic [CntW-1:0]   hi0;
  logic [CntW:0]     sum0;
  stbs_ctrl_t        in_ctrl;

  stbs_ctrl_t       ch_ctrl [NumProbes+1];
  logic [AddrW-1:0] ch_widx [NumProbes+1];
  logic [CntW-1:0]  ch_lo   [NumProbes+1];
  logic [CntW-1:0]  ch_hi   [NumProbes+1];
  logic [CntW-1:0]  ch_mid  [NumProbes+1];
  logic [AddrW-1:0] ch_pos  [NumProbes+1];

  logic            out_valid_q;
  logic            out_found_q;
  logic [PosW-1:0] out_pos_q;

  // Hold the table length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
    end
  end

  // Advance the whole pipeline unless the result register is blocked
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  // Build the entry beat: full range, first midpoint
  always_comb begin
    in_idx = s_axis_tdata[7:0];
    hi0    = (int'(len_q) > TABLE_DEPTH) ? CntW'(TABLE_DEPTH) : CntW'(len_q);
    sum0   = {1'b0, hi0} - (CntW + 1)'(1);

    in_ctrl.valid = s_axis_tvalid;
    in_ctrl.mode  = stbs_mode_e'(s_axis_tuser);
    in_ctrl.wr_ok = int'(in_idx) < TABLE_DEPTH;
    in_ctrl.found = 1'b0;
    in_ctrl.value = s_axis_tdata[39:8];
  end

  assign ch_ctrl[0] = in_ctrl;
  assign ch_widx[0] = AddrW'(in_idx);
  assign ch_lo[0]   = '0;
  assign ch_hi[0]   = hi0;
  assign ch_mid[0]  = sum0[CntW:1];
  assign ch_pos[0]  = '0;

  // One probe stage per halving of the range
  for (genvar s = 0; s < NumProbes; s++) begin : g_probe
    stbs_probe_stage #(
      .TABLE_DEPTH(TABLE_DEPTH)
    ) u_stage (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .in_ctrl_i  (ch_ctrl[s]),
      .in_widx_i  (ch_widx[s]),
      .in_lo_i    (ch_lo[s]),
      .in_hi_i    (ch_hi[s]),
      .in_mid_i   (ch_mid[s]),
      .in_pos_i   (ch_pos[s]),
      .out_ctrl_o (ch_ctrl[s+1]),
      .out_widx_o (ch_widx[s+1]),
      .out_lo_o   (ch_lo[s+1]),
      .out_hi_o   (ch_hi[s+1]),
      .out_mid_o  (ch_mid[s+1]),
      .out_pos_o  (ch_pos[s+1])
    );
  end

  // Register the result; drop write beats here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= ch_ctrl[NumProbes].valid && ch_ctrl[NumProbes].mode == MODE_SEARCH;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_found_q <= ch_ctrl[NumProbes].found;
      out_pos_q   <= PosW'(ch_pos[NumProbes]);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = out_pos_q;

endmodule
